FILE: design/spcsc_pkg.sv
// Shared types, constants and table builders for the stereo peak compressor.
// No dependencies; every other design file imports this package.
package spcsc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int TABLE_ADDR_BITS_DEF = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;
    localparam logic [13:0] LOG2_PER_DB_Q16 = 14'd10885;
    localparam logic [31:0] TWO_LOG2E_X8_Q16 = 32'd1512775;

    localparam logic signed [25:0] FLOOR_LEVEL = -26'sd7864320;
    localparam logic [23:0] CLIP_FULL = 24'd8388608;
    localparam logic [23:0] CLIP_TH = 24'((64'd4 << (SAMPLE_BITS - 1)) / 64'd5);
    localparam logic [23:0] CLIP_W = CLIP_FULL - CLIP_TH;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [2:0] REG_ENABLED = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_SLOPE = 3'd2;
    localparam logic [2:0] REG_ATTACK = 3'd3;
    localparam logic [2:0] REG_RELEASE = 3'd4;
    localparam logic [2:0] REG_MAKEUP = 3'd5;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic               stereo;
        logic               block_end;
    } spcsc_in_t;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic               block_end_out;
    } spcsc_out_t;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic               stereo;
        logic               block_end;
        logic               floor_lvl;
        logic signed [21:0] lg;
    } spcsc_entry_t;

    typedef struct packed {
        logic               enabled;
        logic signed [15:0] threshold_db;
        logic [15:0]        slope;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic signed [13:0] makeup_db;
    } spcsc_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spcsc_qstat_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LVL_MUL,
        BK_OVER,
        BK_TGT_MUL,
        BK_DIFF,
        BK_SM_MUL,
        BK_GR,
        BK_GDB,
        BK_LOG_MUL,
        BK_GAIN,
        BK_APP_MUL,
        BK_APP_SH,
        BK_CLIP,
        BK_CLIP_MUL,
        BK_CH_OUT,
        BK_FINISH
    } spcsc_bstate_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int n = 0; n < 32; n++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // 2^(f/65536) in Q1.30, built from the chain of square roots of two.
    function automatic logic [63:0] pow2_frac(input logic [15:0] f16);
        logic [63:0] acc;
        logic [63:0] r;
        acc = 64'd1 << 30;
        r = 64'd2 << 30;
        for (int k = 1; k <= 16; k++) begin
            r = isqrt64(r << 30);
            if (f16[16 - k]) begin
                acc = mul_q30(acc, r);
            end
        end
        return acc;
    endfunction

    // Restoring long division, used only while tables are elaborated.
    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q = 64'd0;
        rem = 65'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] log2_entry(input int i, input int a);
        logic [63:0] x;
        logic [15:0] res;
        x = (64'd1 << 30) + (64'(i) << (30 - a));
        res = 16'd0;
        for (int b = 15; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                res[b] = 1'b1;
                x = x >> 1;
            end
        end
        return res;
    endfunction

    function automatic logic [30:0] exp2_entry(input int i, input int a);
        return 31'(pow2_frac(16'(i << (16 - a))));
    endfunction

    function automatic logic [29:0] tanh_entry(input int j, input int a);
        logic [63:0] t;
        logic [63:0] n;
        logic [15:0] f;
        logic [63:0] e;
        t = (64'(j) * 64'(TWO_LOG2E_X8_Q16)) >> a;
        n = t >> 16;
        f = t[15:0];
        if (f == 16'd0) begin
            e = (64'd1 << 30) >> n;
        end else begin
            e = pow2_frac(16'(17'h10000 - {1'b0, f})) >> (n + 64'd1);
        end
        return 30'(long_div(((64'd1 << 30) - e) << 30, (64'd1 << 30) + e));
    endfunction

endpackage

FILE: design/stereo_peak_compressor_soft_clip_unit.sv
// The back sequencer works on one item at a time: a bypassed item goes from the queue
// to the output register; with compression enabled it runs the gain steps and then
// the apply and clip steps once per channel, every multiply going through one shared
// 32x32 multiplier. A new item is taken only once the last is in the output register.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the held gain
// reduction to 0 dB and loads the register defaults; the tables are constant logic.
module stereo_peak_compressor_soft_clip_unit
    import spcsc_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  spcsc_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output spcsc_out_t  out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // The configuration registers live here and feed the back section as one bundle.
    // Software must write them only while no transfer is in flight; it is not enforced.
    spcsc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled       <= 1'b0;
            cfg_reg.threshold_db  <= -16'sd1536;
            cfg_reg.slope         <= 16'd32768;
            cfg_reg.attack_coeff  <= 16'd91;
            cfg_reg.release_coeff <= 16'd7;
            cfg_reg.makeup_db     <= 14'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLED:   cfg_reg.enabled       <= cfg_wdata[0];
                REG_THRESHOLD: cfg_reg.threshold_db  <= cfg_wdata;
                REG_SLOPE:     cfg_reg.slope         <= cfg_wdata;
                REG_ATTACK:    cfg_reg.attack_coeff  <= cfg_wdata;
                REG_RELEASE:   cfg_reg.release_coeff <= cfg_wdata;
                REG_MAKEUP:    cfg_reg.makeup_db     <= cfg_wdata[13:0];
                default:
                begin
                end
            endcase
        end
    end

    // The front section classifies each input transfer in the same cycle: it finds the
    // linked peak, the exponent and the log2 mantissa, and writes one queue entry.
    spcsc_qstat_t qstat;
    spcsc_entry_t wr_entry;
    spcsc_entry_t head;
    logic         push;
    logic         pop;

    spcsc_front #(
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .qstat    (qstat),
        .push     (push),
        .wr_entry (wr_entry)
    );

    // The short queue lets the front keep taking transfers while the back section is
    // busy or while a finished result waits on the output side.
    spcsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // The back section converts the level to dB, forms and smooths the gain reduction,
    // applies the gain and the soft clip, and holds the result in the output register.
    spcsc_back #(
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: design/spcsc_queue.sv
// Two-entry queue of classified items between the front and back sections.
// Depends on spcsc_pkg for the entry and status types.
module spcsc_queue
    import spcsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  spcsc_entry_t wr_entry,
    input  logic         pop,
    output spcsc_entry_t head,
    output spcsc_qstat_t qstat
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    spcsc_entry_t slots_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head        = slots_reg[rd_ptr_reg];
    assign qstat.full  = (32'(count_reg) == QUEUE_DEPTH);
    assign qstat.empty = (count_reg == '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from an empty queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

FILE: design/spcsc_front.sv
// Front section: takes input transfers, finds the linked peak and its log2 level.
// Depends on spcsc_pkg for types and the log2 table builder.
module spcsc_front
    import spcsc_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
)
(
    input  logic         in_valid,
    output logic         in_ready,
    input  spcsc_in_t    in_data,
    input  spcsc_qstat_t qstat,
    output logic         push,
    output spcsc_entry_t wr_entry
);

    localparam int TSIZE = 1 << TABLE_ADDR_BITS;

    logic [15:0] log2_rom [TSIZE];

    for (genvar g = 0; g < TSIZE; g++)
    begin : g_log2
        localparam logic [15:0] VAL = log2_entry(g, TABLE_ADDR_BITS);
        assign log2_rom[g] = VAL;
    end

    logic [23:0] mag_l;
    logic [23:0] mag_r;
    logic [23:0] peak;
    logic [4:0]  lead;
    logic [23:0] shifted;
    logic [5:0]  exp_diff;

    always_comb
    begin
        mag_l = in_data.left_sample[23] ? 24'(-in_data.left_sample) : in_data.left_sample;
        if (in_data.stereo)
        begin
            mag_r = in_data.right_sample[23] ? 24'(-in_data.right_sample)
                                             : in_data.right_sample;
        end
        else
        begin
            mag_r = mag_l;
        end
        peak = (mag_l > mag_r) ? mag_l : mag_r;

        lead = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (peak[i])
            begin
                lead = 5'(i);
            end
        end

        // Bits just below the leading one address the log2 mantissa table.
        if (int'(lead) >= TABLE_ADDR_BITS)
        begin
            shifted = peak >> (int'(lead) - TABLE_ADDR_BITS);
        end
        else
        begin
            shifted = peak << (TABLE_ADDR_BITS - int'(lead));
        end
        exp_diff = {1'b0, lead} - 6'd23;

        wr_entry.left_sample  = in_data.left_sample;
        wr_entry.right_sample = in_data.right_sample;
        wr_entry.stereo       = in_data.stereo;
        wr_entry.block_end    = in_data.block_end;
        wr_entry.floor_lvl    = (peak == 24'd0);
        wr_entry.lg           = {exp_diff, log2_rom[shifted[TABLE_ADDR_BITS-1:0]]};
    end

    assign in_ready = !qstat.full;
    assign push     = in_valid && !qstat.full;

endmodule

FILE: design/spcsc_back.sv
// Back section: gain computer, smoother, gain and soft clip on one shared multiplier.
// Depends on spcsc_pkg for types, constants and the exp2 and tanh table builders.
module spcsc_back
    import spcsc_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  spcsc_cfg_t   cfg,
    input  spcsc_entry_t head,
    input  spcsc_qstat_t qstat,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output spcsc_out_t   out_data
);

    localparam int TSIZE = 1 << TABLE_ADDR_BITS;
    localparam int JSHIFT = SAMPLE_BITS + 2 - TABLE_ADDR_BITS;

    logic [30:0] exp2_rom [TSIZE];
    logic [29:0] tanh_rom [TSIZE];

    for (genvar g = 0; g < TSIZE; g++)
    begin : g_tabs
        localparam logic [30:0] EXP_VAL = exp2_entry(g, TABLE_ADDR_BITS);
        localparam logic [29:0] TANH_VAL = tanh_entry(g, TABLE_ADDR_BITS);
        assign exp2_rom[g] = EXP_VAL;
        assign tanh_rom[g] = TANH_VAL;
    end

    spcsc_bstate_t state_reg;
    spcsc_bstate_t state_next;

    spcsc_entry_t       ent_reg;
    logic [20:0]        lgmag_reg;
    logic               chan_reg;
    logic signed [25:0] over_reg;
    logic               up_reg;
    logic [23:0]        diff_reg;
    logic [23:0]        gr_reg;
    logic [23:0]        gr_next;
    logic               gdb_neg_reg;
    logic [24:0]        gdb_mag_reg;
    logic [30:0]        mant_reg;
    logic [5:0]         sh_reg;
    logic               gz_reg;
    logic [29:0]        p_reg;
    logic               clip_reg;
    logic [30:0]        tv_reg;
    logic [23:0]        ol_reg;
    logic [23:0]        or_reg;
    logic [63:0]        prod_reg;
    logic               out_valid_reg;
    spcsc_out_t         out_data_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        load_out;

    // Combinational helpers for the datapath steps.
    logic [23:0]        samp;
    logic [23:0]        samp_mag;
    logic [23:0]        lvl_r;
    logic signed [25:0] level;
    logic signed [25:0] thr_ext;
    logic [23:0]        tgt;
    logic [23:0]        delta;
    logic signed [25:0] gdb;
    logic [22:0]        lg_r;
    logic [23:0]        lg_gain;
    logic signed [8:0]  sh_full;
    logic [63:0]        rnd_sum;
    logic [29:0]        excess;
    logic [32:0]        x5;
    logic [32:0]        jfull;
    logic [23:0]        cout;
    logic [23:0]        pos;
    logic [23:0]        chan_res;

    always_comb
    begin
        samp     = chan_reg ? ent_reg.right_sample : ent_reg.left_sample;
        samp_mag = samp[23] ? 24'(-samp) : samp;

        lvl_r = 24'((prod_reg + 64'd32768) >> 16);
        if (ent_reg.floor_lvl)
        begin
            level = FLOOR_LEVEL;
        end
        else if (ent_reg.lg[21])
        begin
            level = -$signed({2'b00, lvl_r});
        end
        else
        begin
            level = $signed({2'b00, lvl_r});
        end
        thr_ext = {{2{cfg.threshold_db[15]}}, cfg.threshold_db, 8'd0};

        tgt   = prod_reg[39:16];
        delta = 24'((prod_reg + 64'd32768) >> 16);
        gr_next = up_reg ? gr_reg + delta : gr_reg - delta;

        gdb = $signed({{4{cfg.makeup_db[13]}}, cfg.makeup_db, 8'd0}) - $signed({2'b00, gr_reg});

        lg_r    = 23'((prod_reg + 64'd32768) >> 16);
        lg_gain = gdb_neg_reg ? 24'(-{1'b0, lg_r}) : {1'b0, lg_r};
        sh_full = 9'sd30 - $signed({lg_gain[23], lg_gain[23:16]});

        rnd_sum = prod_reg + (64'd1 << (sh_reg - 6'd1));

        excess = p_reg - {6'd0, CLIP_TH};
        x5     = {3'b000, excess} + {1'b0, excess, 2'b00};
        jfull  = x5 >> JSHIFT;

        // Only a positive clipped result saturates; negative full scale is kept.
        cout = CLIP_TH + 24'((prod_reg + (64'd1 << 29)) >> 30);
        if (clip_reg && !samp[23])
        begin
            pos = (cout >= CLIP_FULL) ? CLIP_FULL - 24'd1 : cout;
        end
        else if (clip_reg)
        begin
            pos = cout;
        end
        else
        begin
            pos = p_reg[23:0];
        end
        chan_res = samp[23] ? 24'(-pos) : pos;
    end

    // Shared multiplier operands, chosen by the sequencer step.
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            BK_LVL_MUL:
            begin
                mul_a = 32'(lgmag_reg);
                mul_b = 32'(DB_PER_LOG2_Q16);
            end
            BK_TGT_MUL:
            begin
                mul_a = (over_reg > 26'sd0) ? 32'(over_reg[23:0]) : 32'd0;
                mul_b = 32'(cfg.slope);
            end
            BK_SM_MUL:
            begin
                mul_a = 32'(diff_reg);
                mul_b = up_reg ? 32'(cfg.attack_coeff) : 32'(cfg.release_coeff);
            end
            BK_LOG_MUL:
            begin
                mul_a = 32'(gdb_mag_reg);
                mul_b = 32'(LOG2_PER_DB_Q16);
            end
            BK_APP_MUL:
            begin
                mul_a = 32'(samp_mag);
                mul_b = 32'(mant_reg);
            end
            BK_CLIP_MUL:
            begin
                mul_a = 32'(tv_reg);
                mul_b = 32'(CLIP_W);
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    ent_reg   <= head;
                    lgmag_reg <= head.lg[21] ? 21'(-head.lg) : head.lg[20:0];
                    ol_reg    <= head.left_sample;
                    or_reg    <= head.right_sample;
                    chan_reg  <= 1'b0;
                end
            end
            BK_OVER:
            begin
                over_reg <= level - thr_ext;
            end
            BK_DIFF:
            begin
                up_reg   <= tgt > gr_reg;
                diff_reg <= (tgt > gr_reg) ? tgt - gr_reg : gr_reg - tgt;
            end
            BK_GDB:
            begin
                gdb_neg_reg <= gdb[25];
                gdb_mag_reg <= gdb[25] ? 25'(-gdb) : gdb[24:0];
            end
            BK_GAIN:
            begin
                gz_reg   <= sh_full > 9'sd62;
                sh_reg   <= sh_full[5:0];
                mant_reg <= exp2_rom[lg_gain[15 -: TABLE_ADDR_BITS]];
            end
            BK_APP_SH:
            begin
                p_reg <= gz_reg ? 30'd0 : 30'(rnd_sum >> sh_reg);
            end
            BK_CLIP:
            begin
                clip_reg <= p_reg > {6'd0, CLIP_TH};
                tv_reg   <= (jfull >= 33'(TSIZE)) ? ONE_Q30
                          : {1'b0, tanh_rom[jfull[TABLE_ADDR_BITS-1:0]]};
            end
            BK_CH_OUT:
            begin
                if (chan_reg)
                begin
                    or_reg <= chan_res;
                end
                else
                begin
                    ol_reg <= chan_res;
                end
                chan_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_data_reg.left_out      <= ol_reg;
            out_data_reg.right_out     <= or_reg;
            out_data_reg.block_end_out <= ent_reg.block_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            gr_reg        <= 24'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_GR)
            begin
                gr_reg <= gr_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    state_next = cfg.enabled ? BK_LVL_MUL : BK_FINISH;
                end
            end
            BK_LVL_MUL:  state_next = BK_OVER;
            BK_OVER:     state_next = BK_TGT_MUL;
            BK_TGT_MUL:  state_next = BK_DIFF;
            BK_DIFF:     state_next = BK_SM_MUL;
            BK_SM_MUL:   state_next = BK_GR;
            BK_GR:       state_next = BK_GDB;
            BK_GDB:      state_next = BK_LOG_MUL;
            BK_LOG_MUL:  state_next = BK_GAIN;
            BK_GAIN:     state_next = BK_APP_MUL;
            BK_APP_MUL:  state_next = BK_APP_SH;
            BK_APP_SH:   state_next = BK_CLIP;
            BK_CLIP:     state_next = BK_CLIP_MUL;
            BK_CLIP_MUL: state_next = BK_CH_OUT;
            BK_CH_OUT:
            begin
                state_next = (!chan_reg && ent_reg.stereo) ? BK_APP_MUL : BK_FINISH;
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
